// ===== hdl/sxl_pkg.sv =====
// Shared types and constants for the s-expression token lexer.
// Used by sxl_core, sxl_resq and sexpr_token_lexer; no dependencies.
`timescale 1ns / 1ps

package sxl_pkg;

  localparam int MAX_STRING = 128;
  // string content bytes kept before the string counts as too long
  localparam logic [31:0] STR_KEEP_MAX = 32'(MAX_STRING - 3);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    TK_TEXT     = 4'd0,
    TK_LPAREN   = 4'd1,
    TK_RPAREN   = 4'd2,
    TK_LBRACE   = 4'd3,
    TK_RBRACE   = 4'd4,
    TK_STRING   = 4'd5,
    TK_INT      = 4'd6,
    TK_CHAR     = 4'd7,
    TK_KEYWORD  = 4'd8,
    TK_SYMBOL   = 4'd9,
    TK_ERR_QUOTE = 4'd10,
    TK_ERR_HEX  = 4'd11,
    TK_ERR_DEC  = 4'd12,
    TK_ERR_LONG = 4'd13,
    TK_END      = 4'd14
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  text;
    logic [31:0] value;
    logic [7:0]  length;
  } tok_res_t;

  typedef struct packed {
    tok_res_t res;
    logic     last;
  } q_entry_t;

endpackage

// ===== hdl/sxl_core.sv =====
// Lexer state and per-byte step logic: mode machine, atom accumulators,
// string escapes; produces up to two results per step. Uses sxl_pkg.
`timescale 1ns / 1ps

module sxl_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       src_byte,
  input  logic             src_end,
  output logic [1:0]       res_n,
  output sxl_pkg::tok_res_t res_a,
  output sxl_pkg::tok_res_t res_b
);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ATOM = 4'b0010,
    MODE_STR  = 4'b0100,
    MODE_CMT  = 4'b1000
  } lex_mode_t;

  function automatic sxl_pkg::tok_res_t mk_res(sxl_pkg::tok_kind_t kind, logic [7:0] text,
                                               logic [31:0] value, logic [7:0] length);
    sxl_pkg::tok_res_t r;
    r.kind   = kind;
    r.text   = text;
    r.value  = value;
    r.length = length;
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_COMMA) ||
           (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] d;
    d = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) d = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) d = {1'b1, 4'(c - 8'h57)};
    return d;
  endfunction

  function automatic sxl_pkg::tok_kind_t bracket_kind(logic [7:0] c);
    sxl_pkg::tok_kind_t k;
    k = sxl_pkg::TK_TEXT;
    if (c == CH_LPAREN) k = sxl_pkg::TK_LPAREN;
    else if (c == CH_RPAREN) k = sxl_pkg::TK_RPAREN;
    else if (c == CH_LBRACE) k = sxl_pkg::TK_LBRACE;
    else if (c == CH_RBRACE) k = sxl_pkg::TK_RBRACE;
    return k;
  endfunction

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic sxl_pkg::tok_res_t atom_finish(
      logic [7:0] len, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
      logic hok, logic dok, logic [31:0] hacc, logic [31:0] dacc);
    sxl_pkg::tok_res_t r;
    if (b0 == CH_ZERO && len >= 8'd2 && b1 == CH_X) begin
      r = hok ? mk_res(sxl_pkg::TK_INT, 8'h00, hacc, len)
              : mk_res(sxl_pkg::TK_ERR_HEX, 8'h00, 32'h0, len);
    end else if (is_digit(b0)) begin
      r = dok ? mk_res(sxl_pkg::TK_INT, 8'h00, dacc, len)
              : mk_res(sxl_pkg::TK_ERR_DEC, 8'h00, 32'h0, len);
    end else if (b0 == CH_APOS && len == 8'd3 && b2 == CH_APOS) begin
      r = mk_res(sxl_pkg::TK_CHAR, b1, 32'h0, len);
    end else if (b0 == CH_COLON) begin
      r = mk_res(sxl_pkg::TK_KEYWORD, 8'h00, 32'h0, len);
    end else begin
      r = mk_res(sxl_pkg::TK_SYMBOL, 8'h00, 32'h0, len);
    end
    return r;
  endfunction

  lex_mode_t   mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [31:0] hacc_r, hacc_nxt;
  logic [31:0] dacc_r, dacc_nxt;
  logic        hok_r, hok_nxt;
  logic        dok_r, dok_nxt;

  logic                do_take;
  logic                second_put;
  logic [7:0]          esc_char;
  logic [4:0]          hdig;
  sxl_pkg::tok_kind_t  bk;
  sxl_pkg::tok_res_t   fin;

  assign bk  = bracket_kind(src_byte);
  assign fin = atom_finish(len_r, b0_r, b1_r, b2_r, hok_r, dok_r, hacc_r, dacc_r);
  assign hdig = hex_digit(src_byte);

  always_comb begin
    mode_nxt   = mode_r;
    esc_nxt    = esc_r;
    len_nxt    = len_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;
    b2_nxt     = b2_r;
    hacc_nxt   = hacc_r;
    dacc_nxt   = dacc_r;
    hok_nxt    = hok_r;
    dok_nxt    = dok_r;
    res_n      = 2'd0;
    res_a      = mk_res(sxl_pkg::TK_END, 8'h00, 32'h0, 8'h00);
    res_b      = mk_res(sxl_pkg::TK_END, 8'h00, 32'h0, 8'h00);
    do_take    = 1'b0;
    second_put = 1'b0;
    esc_char   = CH_BSLASH;

    if (src_end) begin
      mode_nxt = MODE_IDLE;
      esc_nxt  = 1'b0;
      if (mode_r == MODE_ATOM) begin
        res_a = fin;
        res_n = 2'd2;
      end else if (mode_r == MODE_STR) begin
        res_a = mk_res(sxl_pkg::TK_ERR_QUOTE, 8'h00, 32'h0, len_r);
        res_n = 2'd2;
      end else begin
        res_a = mk_res(sxl_pkg::TK_END, 8'h00, 32'h0, 8'h00);
        res_n = 2'd1;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (is_blank(src_byte)) begin
            // skipped
          end else if (src_byte == CH_SEMI) begin
            mode_nxt = MODE_CMT;
          end else if (bk != sxl_pkg::TK_TEXT) begin
            res_a = mk_res(bk, src_byte, 32'h0, 8'd1);
            res_n = 2'd1;
          end else begin
            len_nxt  = 8'd0;
            hacc_nxt = 32'h0;
            hok_nxt  = 1'b1;
            esc_nxt  = 1'b0;
            if (src_byte == CH_QUOTE) begin
              mode_nxt = MODE_STR;
            end else begin
              mode_nxt = MODE_ATOM;
              b0_nxt   = 8'h00;
              b1_nxt   = 8'h00;
              b2_nxt   = 8'h00;
              dacc_nxt = 32'h0;
              dok_nxt  = 1'b1;
              do_take  = 1'b1;
            end
          end
        end
        MODE_CMT: begin
          if (src_byte == CH_NL) mode_nxt = MODE_IDLE;
        end
        MODE_ATOM: begin
          if (is_blank(src_byte)) begin
            mode_nxt = MODE_IDLE;
            res_a    = fin;
            res_n    = 2'd1;
          end else if (bk != sxl_pkg::TK_TEXT) begin
            mode_nxt = MODE_IDLE;
            res_a    = fin;
            res_b    = mk_res(bk, src_byte, 32'h0, 8'd1);
            res_n    = 2'd2;
          end else begin
            do_take = 1'b1;
          end
        end
        MODE_STR: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (src_byte == CH_QUOTE) esc_char = CH_QUOTE;
            else if (src_byte == CH_N) esc_char = CH_NL;
            else begin
              esc_char = CH_BSLASH;
              if (src_byte == CH_BSLASH) esc_nxt = 1'b1;
              else second_put = 1'b1;
            end
            // first put; the second can only succeed if the first did
            if (hacc_r < sxl_pkg::STR_KEEP_MAX) begin
              hacc_nxt = hacc_r + 32'd1;
              len_nxt  = sat_inc(len_r);
              res_a    = mk_res(sxl_pkg::TK_TEXT, esc_char, 32'h0, 8'h00);
              res_n    = 2'd1;
            end else begin
              hok_nxt = 1'b0;
            end
            if (second_put) begin
              if (hacc_nxt < sxl_pkg::STR_KEEP_MAX) begin
                hacc_nxt = hacc_nxt + 32'd1;
                len_nxt  = sat_inc(len_nxt);
                res_b    = mk_res(sxl_pkg::TK_TEXT, src_byte, 32'h0, 8'h00);
                res_n    = 2'd2;
              end else begin
                hok_nxt = 1'b0;
              end
            end
          end else if (src_byte == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            res_a    = mk_res(hok_r ? sxl_pkg::TK_STRING : sxl_pkg::TK_ERR_LONG,
                              8'h00, 32'h0, len_r);
            res_n    = 2'd1;
          end else if (src_byte == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (hacc_r < sxl_pkg::STR_KEEP_MAX) begin
            hacc_nxt = hacc_r + 32'd1;
            len_nxt  = sat_inc(len_r);
            res_a    = mk_res(sxl_pkg::TK_TEXT, src_byte, 32'h0, 8'h00);
            res_n    = 2'd1;
          end else begin
            hok_nxt = 1'b0;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase

      if (do_take) begin
        if (len_nxt == 8'd0) b0_nxt = src_byte;
        else if (len_nxt == 8'd1) b1_nxt = src_byte;
        else if (len_nxt == 8'd2) b2_nxt = src_byte;
        if (is_digit(src_byte)) begin
          // x*10 = x*8 + x*2
          dacc_nxt = {dacc_nxt[28:0], 3'b000} + {dacc_nxt[30:0], 1'b0} +
                     {24'h0, src_byte - CH_ZERO};
        end else begin
          dok_nxt = 1'b0;
        end
        if (len_nxt >= 8'd2) begin
          if (hdig[4]) hacc_nxt = {hacc_nxt[27:0], hdig[3:0]};
          else hok_nxt = 1'b0;
        end
        len_nxt = sat_inc(len_nxt);
        res_a   = mk_res(sxl_pkg::TK_TEXT, src_byte, 32'h0, 8'h00);
        res_n   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      len_r  <= 8'h00;
      b0_r   <= 8'h00;
      b1_r   <= 8'h00;
      b2_r   <= 8'h00;
      hacc_r <= 32'h0;
      dacc_r <= 32'h0;
      hok_r  <= 1'b1;
      dok_r  <= 1'b1;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      len_r  <= len_nxt;
      b0_r   <= b0_nxt;
      b1_r   <= b1_nxt;
      b2_r   <= b2_nxt;
      hacc_r <= hacc_nxt;
      dacc_r <= dacc_nxt;
      hok_r  <= hok_nxt;
      dok_r  <= dok_nxt;
    end
  end

endmodule

// ===== hdl/sxl_resq.sv =====
// Result queue: takes up to two results per cycle, hands out one per
// transfer. Register-based, QDEPTH entries. Uses sxl_pkg.
`timescale 1ns / 1ps

module sxl_resq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         wr_n,
  input  sxl_pkg::q_entry_t  wr_a,
  input  sxl_pkg::q_entry_t  wr_b,
  output logic               room2,
  output logic               rd_valid,
  input  logic               rd_stall,
  output sxl_pkg::q_entry_t  rd_data
);

  sxl_pkg::q_entry_t                   q_r [sxl_pkg::QDEPTH];
  logic [sxl_pkg::QPTR_W-1:0]          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [sxl_pkg::QCNT_W-1:0]          cnt_r, cnt_nxt;
  logic [sxl_pkg::QPTR_W-1:0]          wp_b;
  logic                                rd;

  assign rd_valid = (cnt_r != '0);
  assign rd       = rd_valid && !rd_stall;
  assign rd_data  = q_r[rp_r];
  assign room2    = (cnt_r <= sxl_pkg::QCNT_W'(sxl_pkg::QDEPTH - 2));
  assign wp_b     = wp_r + sxl_pkg::QPTR_W'(1);

  always_comb begin
    wp_nxt  = wp_r + sxl_pkg::QPTR_W'(wr_n);
    rp_nxt  = rp_r + sxl_pkg::QPTR_W'(rd);
    cnt_nxt = cnt_r + sxl_pkg::QCNT_W'(wr_n) - sxl_pkg::QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) q_r[wp_r] <= wr_a;
    if (wr_n == 2'd2) q_r[wp_b] <= wr_b;
  end

endmodule

// ===== hdl/sexpr_token_lexer.sv =====
// Top level of the s-expression token lexer: input register, step logic
// (sxl_core) and result queue (sxl_resq). Uses sxl_pkg.
//
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------
//  in_     | input     | in_source_byte, in_end_of_input
//  out_    | output    | out_token_kind, out_text_byte, out_int_value,
//          |           | out_token_length, out_last_of_run
//
// One source byte per cycle while in_stall is low: the byte is registered,
// then one step of sxl_core makes zero, one or two results from it.
// Results leave one per cycle while out_stall is low, through a four-entry
// queue; a step waits only while fewer than two queue entries are free.
// Reset (rst_n low, synchronous) empties both stages and idles the lexer.
// in_stall rises only when the input register holds a byte and the queue
// is near full; out_stall holds results in the queue.
`timescale 1ns / 1ps

module sexpr_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [7:0]  out_text_byte,
  output logic signed [31:0] out_int_value,
  output logic [7:0]  out_token_length,
  output logic        out_last_of_run
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_end_r;
  logic              room2;
  logic              adv;
  logic              load;
  logic [1:0]        res_n;
  logic [1:0]        wr_n;
  sxl_pkg::tok_res_t res_a, res_b;
  sxl_pkg::q_entry_t wr_a, wr_b, rd_data;

  assign adv      = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;
  assign load     = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (load) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      in_byte_r <= in_source_byte;
      in_end_r  <= in_end_of_input;
    end
  end

  sxl_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (adv),
    .src_byte (in_byte_r),
    .src_end  (in_end_r),
    .res_n    (res_n),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  assign wr_n      = adv ? res_n : 2'd0;
  assign wr_a.res  = res_a;
  assign wr_a.last = (res_n == 2'd1);
  assign wr_b.res  = res_b;
  assign wr_b.last = 1'b1;

  sxl_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_n     (wr_n),
    .wr_a     (wr_a),
    .wr_b     (wr_b),
    .room2    (room2),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (rd_data)
  );

  assign out_token_kind   = rd_data.res.kind;
  assign out_text_byte    = rd_data.res.text;
  assign out_int_value    = rd_data.res.value;
  assign out_token_length = rd_data.res.length;
  assign out_last_of_run  = rd_data.last;

endmodule
